FILE: rtl/masr_pkg.sv
// shared types and constants for the moving average spike reject block
`timescale 1ns / 1ps

package masr_pkg;

  // window length per sensor and number of sensors (window must be a power of two)
  localparam int WINDOW   = 8;
  localparam int SENSORS  = 8;

  // field widths
  localparam int SID_W    = 3;
  localparam int SAMPLE_W = 12;
  localparam int THRESH_W = 11;

  // derived widths and depths
  localparam int WIN_W       = $clog2(WINDOW);
  localparam int SUM_W       = SAMPLE_W + WIN_W;
  localparam int SIDX_W      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int STORE_DEPTH = SENSORS * WINDOW;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int DIFF_W      = SAMPLE_W + 1;

  // threshold after reset: 2.0 degrees in 1/16 degree units
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(32);

  // input transaction payload
  typedef struct packed {
    logic [SID_W-1:0]           sensor_id;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       spike;
  } out_item_t;

endpackage

FILE: rtl/masr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module masr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: rtl/moving_average_spike_reject.sv
// top level: per-sensor moving average with spike bypass
`timescale 1ns / 1ps

// Per-sensor moving average filter with spike bypass.
// Input channel (in_valid / in_stall / in_data): one sample tagged with a
// sensor number per transaction. Result channel (out_valid / out_stall /
// out_data): one result per input transaction, in input order; filtered is
// the window average, or the raw sample with spike set when the sample is
// more than the threshold away from the average.
// cfg_wr_en / cfg_wr_data write the spike threshold; write only while idle.
// The first stage registers the accepted transaction and reads the
// oldest sample of the sensor's ring from the sample ram; the second
// stage updates the running sum, writes the new sample back and loads
// the output register, which drives out_valid. Throughput: one
// transaction per cycle while the result channel does not stall.
// Reset (rst_n low, synchronous): every ring entry reads as zero through
// per-entry valid bits, sums and ring positions clear, threshold returns
// to 32; there is no clearing pass, the block is ready right after reset.
// When the receiver stalls, the result holds in the output register; one
// more transaction can sit in the second stage, after which in_stall
// rises in the same cycle.
module moving_average_spike_reject
  import masr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [THRESH_W-1:0] cfg_wr_data
);

  logic [THRESH_W-1:0]        thresh_r;
  logic [WIN_W-1:0]           pos_r [SENSORS];
  logic signed [SUM_W-1:0]    sum_r [SENSORS];
  logic [STORE_DEPTH-1:0]     slot_vld_r;

  logic                       s1_valid_r;
  logic                       s1_known_r;
  logic [SIDX_W-1:0]          s1_sidx_r;
  logic [SLOT_W-1:0]          s1_slot_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_old_vld_r;

  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic                       in_acc;
  logic                       s1_adv;
  logic                       in_known;
  logic [SIDX_W-1:0]          in_sidx;
  logic [WIN_W-1:0]           in_pos;
  logic [WIN_W-1:0]           pos_nxt;
  logic [SLOT_W-1:0]          rd_slot;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       ram_we;

  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SUM_W-1:0]    sum_biased;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          abs_diff;
  logic                       spike_det;
  out_item_t                  out_data_nxt;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // ring slot of the sensor's oldest sample
  assign in_known = ({1'b0, in_data.sensor_id} < (SID_W + 1)'(SENSORS));
  assign in_sidx  = SIDX_W'(in_data.sensor_id);
  assign in_pos   = in_known ? pos_r[in_sidx] : '0;
  assign pos_nxt  = (in_pos == WIN_W'(WINDOW - 1)) ? '0 : in_pos + WIN_W'(1);
  assign rd_slot  = SLOT_W'(in_sidx) * SLOT_W'(WINDOW) + SLOT_W'(in_pos);

  // write back the new sample when the second stage completes
  assign ram_we = s1_adv && s1_known_r;

  masr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot_r),
    .wdata (s1_sample_r),
    .re    (in_acc),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // ring positions advance at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        pos_r[i] <= '0;
      end
    end else if (in_acc && in_known) begin
      pos_r[in_sidx] <= pos_nxt;
    end
  end

  // first stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_known_r   <= in_known;
      s1_sidx_r    <= in_sidx;
      s1_slot_r    <= rd_slot;
      s1_sample_r  <= in_data.sample;
      s1_old_vld_r <= slot_vld_r[rd_slot];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (ram_we) begin
      slot_vld_r[s1_slot_r] <= 1'b1;
    end
  end

  // running sum update, average and spike test
  always_comb begin
    old_sample = s1_old_vld_r ? $signed(ram_rdata) : '0;
    sum_nxt    = sum_r[s1_sidx_r] - SUM_W'(old_sample) + SUM_W'(s1_sample_r);
    sum_biased = sum_nxt + (sum_nxt[SUM_W-1] ? SUM_W'(WINDOW - 1) : SUM_W'(0));
    avg        = SAMPLE_W'(sum_biased >>> WIN_W);
    diff       = DIFF_W'(s1_sample_r) - DIFF_W'(avg);
    abs_diff   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    spike_det  = abs_diff > DIFF_W'(thresh_r);

    out_data_nxt.filtered = s1_sample_r;
    out_data_nxt.spike    = 1'b0;
    if (s1_known_r) begin
      out_data_nxt.filtered = spike_det ? s1_sample_r : avg;
      out_data_nxt.spike    = spike_det;
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        sum_r[i] <= '0;
      end
    end else if (ram_we) begin
      sum_r[s1_sidx_r] <= sum_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // an accepted transaction always lands in the second stage
  a_acc_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction did not reach second stage");

  // read and write back never hit the same ring slot in one cycle
  a_no_slot_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_known && ram_we) |-> (rd_slot != s1_slot_r))
    else $error("ring slot read and written in the same cycle");

  // a new result only follows a completed second stage
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a second stage transaction");
`endif

endmodule
